[sv/sptc_pkg.sv]
// Shared constants, types and register codes for the six-point texture code block.
package sptc_pkg;

   // Geometry of the window and the line stores.
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int WINDOW_RADIUS = 2;
   localparam int WIN           = 2 * WINDOW_RADIUS + 1;
   localparam int LINES         = WIN - 1;
   localparam int EDGE_MIN      = 2 * WINDOW_RADIUS;

   // Field widths.
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int PIX_W  = CH_W * NUM_CH;
   localparam int CODE_W = 6;
   localparam int POS_W  = 11;
   localparam int CFG_W  = 12;
   localparam int HYST_W = 8;

   // Output queue.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

   // Register port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_IMAGE_WIDTH  = 2'd0;
   localparam reg_index_type REG_IMAGE_HEIGHT = 2'd1;
   localparam reg_index_type REG_HYSTERESIS   = 2'd2;

   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 12'd480;
   localparam logic [HYST_W-1:0] HYST_RESET   = 8'd3;
   localparam logic [CFG_W-1:0]  ROW_LIMIT    = 12'd2048;

   // Neighbor positions in the window, in code bit order.
   localparam int NB_ROW [CODE_W] = '{0, 1, 1, 3, 3, 4};
   localparam int NB_COL [CODE_W] = '{2, 0, 4, 0, 4, 2};

   typedef logic [PIX_W-1:0]            pixel_type;
   typedef pixel_type [WIN-1:0]         win_row_type;
   typedef logic [CH_W-1:0]             sample_type;
   typedef sample_type [CODE_W-1:0]     nb_set_type;

   // Per-cycle controls handed to each cell of the chain.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic shift_en;
   } cell_ctl_type;

   typedef struct packed {
      logic             code_valid;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } centre_type;

   typedef struct packed {
      centre_type                       pos;
      logic [NUM_CH-1:0][CODE_W-1:0]    codes;
   } result_type;

endpackage

[sv/six_point_texture_code_core.sv]
// Top level of the six-point texture code block: counters, cell chain, output queue.
//
// A raster stream of 3-channel 8-bit pixels enters on the req_ channel, one
// item per clock at full rate. req_frame_start marks pixel (0,0) of a frame.
// For every item one result leaves on the rsp_ channel: the 6-bit texture
// codes of the pixel two rows and two columns back, with its position, or
// all zeros with rsp_code_valid low when that pixel lies within two pixels
// of a border. Items are taken while valid is high and stall is low.
// Throughput is one item per cycle unless stalled; each of the four line
// stores does one read and one write per cycle, and the write of an item
// lands in the cycle after its read. Results wait in a four-entry queue;
// req_stall rises when the queue and the two items in flight would fill
// it, so a stalled receiver holds the input back after at most four items.
// Image width, height and hysteresis are written on the csr_ port; the user
// must do so only while the block is idle; the block does not enforce it.
// Reset clears the counters, the queue and the registers (640, 480, 3).
// Line stores are not cleared; no valid code reads an unwritten entry.
module six_point_texture_code_core #(
   parameter int MAX_WIDTH = sptc_pkg::MAX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_frame_start,
   input  logic [sptc_pkg::CH_W-1:0]        req_pixel_ch0,
   input  logic [sptc_pkg::CH_W-1:0]        req_pixel_ch1,
   input  logic [sptc_pkg::CH_W-1:0]        req_pixel_ch2,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_code_valid,
   output logic [sptc_pkg::POS_W-1:0]       rsp_centre_column,
   output logic [sptc_pkg::POS_W-1:0]       rsp_centre_row,
   output logic [sptc_pkg::CODE_W-1:0]      rsp_code_ch0,
   output logic [sptc_pkg::CODE_W-1:0]      rsp_code_ch1,
   output logic [sptc_pkg::CODE_W-1:0]      rsp_code_ch2,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sptc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sptc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sptc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LIM_W = $clog2(MAX_WIDTH + 1);
   localparam logic [sptc_pkg::CFG_W:0] MAX_WIDTH_LIM = (sptc_pkg::CFG_W + 1)'(MAX_WIDTH);
   localparam int CNT_W = sptc_pkg::OUT_PTR_W + 1;

   // ---------------------------------------------------------------------
   // Configuration registers.
   logic [sptc_pkg::CFG_W-1:0]  cfg_width_ff;
   logic [sptc_pkg::CFG_W-1:0]  cfg_height_ff;
   logic [sptc_pkg::HYST_W-1:0] cfg_hyst_ff;
   sptc_pkg::reg_index_type     csr_index;
   logic                        csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= sptc_pkg::WIDTH_RESET;
         cfg_height_ff <= sptc_pkg::HEIGHT_RESET;
         cfg_hyst_ff   <= sptc_pkg::HYST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sptc_pkg::REG_IMAGE_WIDTH: begin
               cfg_width_ff <= csr_pwdata[sptc_pkg::CFG_W-1:0];
            end
            sptc_pkg::REG_IMAGE_HEIGHT: begin
               cfg_height_ff <= csr_pwdata[sptc_pkg::CFG_W-1:0];
            end
            sptc_pkg::REG_HYSTERESIS: begin
               cfg_hyst_ff <= csr_pwdata[sptc_pkg::HYST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         sptc_pkg::REG_IMAGE_WIDTH:  csr_prdata = sptc_pkg::CSR_DATA_W'(cfg_width_ff);
         sptc_pkg::REG_IMAGE_HEIGHT: csr_prdata = sptc_pkg::CSR_DATA_W'(cfg_height_ff);
         sptc_pkg::REG_HYSTERESIS:   csr_prdata = sptc_pkg::CSR_DATA_W'(cfg_hyst_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Effective line length and frame height, zero acting as one, large values clamped.
   logic [sptc_pkg::CFG_W:0]   width_ext;
   logic [sptc_pkg::CFG_W:0]   width_lim_ext;
   logic [LIM_W-1:0]           width_lim;
   logic [sptc_pkg::CFG_W-1:0] height_lim;

   always_comb begin
      width_ext = {1'b0, cfg_width_ff};
      if (cfg_width_ff == '0) begin
         width_lim_ext = (sptc_pkg::CFG_W + 1)'(1);
      end else if (width_ext > MAX_WIDTH_LIM) begin
         width_lim_ext = MAX_WIDTH_LIM;
      end else begin
         width_lim_ext = width_ext;
      end
      width_lim = width_lim_ext[LIM_W-1:0];

      if (cfg_height_ff == '0) begin
         height_lim = sptc_pkg::CFG_W'(1);
      end else if (cfg_height_ff > sptc_pkg::ROW_LIMIT) begin
         height_lim = sptc_pkg::ROW_LIMIT;
      end else begin
         height_lim = cfg_height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Acceptance and raster counters.
   logic                          accept;
   logic [COL_W-1:0]              col_ff;
   logic [COL_W-1:0]              col_in;
   logic [sptc_pkg::POS_W-1:0]    row_ff;
   logic [sptc_pkg::POS_W-1:0]    row_in;
   logic [COL_W-1:0]              col_cur;
   logic [sptc_pkg::POS_W-1:0]    row_cur;
   logic [LIM_W-1:0]              col_ext;
   logic [LIM_W-1:0]              col_next_ext;
   logic [sptc_pkg::CFG_W-1:0]    row_ext;
   logic [sptc_pkg::CFG_W-1:0]    row_next_ext;
   sptc_pkg::centre_type          pos_cur;

   logic                          s1_valid_ff;
   logic [COL_W-1:0]              s1_col_ff;
   sptc_pkg::pixel_type           s1_px_ff;
   sptc_pkg::centre_type          s1_pos_ff;
   logic                          s2_valid_ff;
   sptc_pkg::centre_type          s2_pos_ff;

   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              in_flight;

   assign accept = req_valid && !req_stall;

   always_comb begin
      col_cur      = req_frame_start ? '0 : col_ff;
      row_cur      = req_frame_start ? '0 : row_ff;
      col_ext      = LIM_W'(col_cur);
      col_next_ext = col_ext + LIM_W'(1);
      row_ext      = {1'b0, row_cur};
      row_next_ext = row_ext + sptc_pkg::CFG_W'(1);

      // The centre must sit two pixels inside every border.
      pos_cur.code_valid = (col_cur >= COL_W'(sptc_pkg::EDGE_MIN)) &&
                           (row_cur >= sptc_pkg::POS_W'(sptc_pkg::EDGE_MIN)) &&
                           (col_ext < width_lim) && (row_ext < height_lim);
      pos_cur.col = sptc_pkg::POS_W'(col_cur - COL_W'(sptc_pkg::WINDOW_RADIUS));
      pos_cur.row = row_cur - sptc_pkg::POS_W'(sptc_pkg::WINDOW_RADIUS);

      // Advance; a counter at or past its limit wraps.
      if (col_next_ext >= width_lim) begin
         col_in = '0;
         if (row_next_ext >= height_lim) begin
            row_in = '0;
         end else begin
            row_in = row_next_ext[sptc_pkg::POS_W-1:0];
         end
      end else begin
         col_in = col_next_ext[COL_W-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Two pipeline stages: line store read, then window shift and code.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= col_cur;
         s1_px_ff  <= {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
         s1_pos_ff <= pos_cur;
      end
      if (s1_valid_ff) begin
         s2_pos_ff <= s1_pos_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Chain of cells: cell k keeps line k and window row LINES-1-k.
   sptc_pkg::cell_ctl_type cell_ctl;
   sptc_pkg::pixel_type    cell_din  [sptc_pkg::LINES];
   sptc_pkg::pixel_type    cell_dout [sptc_pkg::LINES];
   sptc_pkg::win_row_type  cell_taps [sptc_pkg::LINES];

   assign cell_ctl.rd_en    = accept;
   assign cell_ctl.wr_en    = s1_valid_ff;
   assign cell_ctl.shift_en = s1_valid_ff;
   assign cell_din[0]       = s1_px_ff;

   for (genvar k = 0; k < sptc_pkg::LINES; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign cell_din[k] = cell_dout[k-1];
      end
      sptc_cell #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .rd_addr (col_cur),
         .wr_addr (s1_col_ff),
         .d_in    (cell_din[k]),
         .d_out   (cell_dout[k]),
         .taps    (cell_taps[k])
      );
   end

   // Bottom window row holds the incoming pixels themselves.
   sptc_pkg::win_row_type px_taps_ff;
   sptc_pkg::win_row_type px_taps_in;

   always_comb begin
      for (int j = 0; j < sptc_pkg::WIN - 1; j++) begin
         px_taps_in[j] = px_taps_ff[j+1];
      end
      px_taps_in[sptc_pkg::WIN-1] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         px_taps_ff <= px_taps_in;
      end
   end

   // Assemble the 5x5 window, oldest row first.
   sptc_pkg::win_row_type win [sptc_pkg::WIN];

   always_comb begin
      for (int r = 0; r < sptc_pkg::LINES; r++) begin
         win[r] = cell_taps[sptc_pkg::LINES-1-r];
      end
      win[sptc_pkg::WIN-1] = px_taps_ff;
   end

   // Texture codes, one unit per channel.
   logic [sptc_pkg::NUM_CH-1:0][sptc_pkg::CODE_W-1:0] codes;

   for (genvar ch = 0; ch < sptc_pkg::NUM_CH; ch++) begin : g_chan
      sptc_pkg::nb_set_type nb;
      for (genvar b = 0; b < sptc_pkg::CODE_W; b++) begin : g_nb
         assign nb[b] =
            win[sptc_pkg::NB_ROW[b]][sptc_pkg::NB_COL[b]][ch*sptc_pkg::CH_W +: sptc_pkg::CH_W];
      end
      sptc_code u_code (
         .hysteresis (cfg_hyst_ff),
         .centre     (win[sptc_pkg::WINDOW_RADIUS][sptc_pkg::WINDOW_RADIUS]
                         [ch*sptc_pkg::CH_W +: sptc_pkg::CH_W]),
         .neighbors  (nb),
         .code       (codes[ch])
      );
   end

   // ---------------------------------------------------------------------
   // Output queue.
   sptc_pkg::result_type           out_q_ff [sptc_pkg::OUT_DEPTH];
   sptc_pkg::result_type           push_item;
   logic [sptc_pkg::OUT_PTR_W-1:0] head_ff;
   logic [sptc_pkg::OUT_PTR_W-1:0] tail_ff;
   logic                           push;
   logic                           pop;

   assign push = s2_valid_ff;
   assign pop  = (count_ff != '0) && !rsp_stall;

   // Fields of an item without a valid centre read as zero.
   always_comb begin
      if (s2_pos_ff.code_valid) begin
         push_item.pos   = s2_pos_ff;
         push_item.codes = codes;
      end else begin
         push_item = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_q_ff[tail_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + sptc_pkg::OUT_PTR_W'(1);
         end
         if (pop) begin
            head_ff <= head_ff + sptc_pkg::OUT_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Hold the input back when queued plus in-flight items fill the queue.
   assign in_flight = count_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid_ff);
   assign req_stall = in_flight >= CNT_W'(sptc_pkg::OUT_DEPTH);

   assign rsp_valid         = count_ff != '0;
   assign rsp_code_valid    = out_q_ff[head_ff].pos.code_valid;
   assign rsp_centre_column = out_q_ff[head_ff].pos.col;
   assign rsp_centre_row    = out_q_ff[head_ff].pos.row;
   assign rsp_code_ch0      = out_q_ff[head_ff].codes[0];
   assign rsp_code_ch1      = out_q_ff[head_ff].codes[1];
   assign rsp_code_ch2      = out_q_ff[head_ff].codes[2];

endmodule

[sv/sptc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sptc_ram #(
   parameter int WIDTH = sptc_pkg::PIX_W,
   parameter int DEPTH = sptc_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sptc_cell.sv]
// One cell of the chain: a line store and the window row fed from it.
module sptc_cell #(
   parameter int MAX_WIDTH = sptc_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sptc_pkg::cell_ctl_type       ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  sptc_pkg::pixel_type          d_in,
   output sptc_pkg::pixel_type          d_out,
   output sptc_pkg::win_row_type        taps
);

   sptc_pkg::pixel_type   ram_q;
   sptc_pkg::pixel_type   byp_ff;
   logic                  hit_ff;
   sptc_pkg::win_row_type taps_ff;
   sptc_pkg::win_row_type taps_in;

   // Line store: the item's column is read on acceptance and rewritten in the
   // next cycle with the value handed down from the previous cell or input.
   sptc_ram #(
      .WIDTH (sptc_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (d_in),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // A read that meets a write to the same column in the same cycle takes
   // the value being written.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         hit_ff <= ctl.wr_en && (rd_addr == wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         byp_ff <= d_in;
      end
   end

   assign d_out = hit_ff ? byp_ff : ram_q;

   // Window row: shift left, newest sample enters at the right end.
   always_comb begin
      for (int j = 0; j < sptc_pkg::WIN - 1; j++) begin
         taps_in[j] = taps_ff[j+1];
      end
      taps_in[sptc_pkg::WIN-1] = d_out;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_en) begin
         taps_ff <= taps_in;
      end
   end

   assign taps = taps_ff;

endmodule

[sv/sptc_code.sv]
// Six-bit texture code of one channel from the centre and its six neighbors.
module sptc_code (
   input  logic [sptc_pkg::HYST_W-1:0] hysteresis,
   input  sptc_pkg::sample_type        centre,
   input  sptc_pkg::nb_set_type        neighbors,
   output logic [sptc_pkg::CODE_W-1:0] code
);

   logic [sptc_pkg::CH_W:0] lhs;

   // Centre minus neighbor plus hysteresis is non-negative exactly when
   // centre plus hysteresis reaches the neighbor.
   always_comb begin
      lhs = {1'b0, centre} + {1'b0, hysteresis};
      for (int b = 0; b < sptc_pkg::CODE_W; b++) begin
         code[b] = lhs >= {1'b0, neighbors[b]};
      end
   end

endmodule

[sv/sptc_checker.sv]
// Port-level checks of the six-point texture code block, bound to the top level.
module sptc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_code_valid,
   input logic [sptc_pkg::POS_W-1:0]      rsp_centre_column,
   input logic [sptc_pkg::POS_W-1:0]      rsp_centre_row,
   input logic [sptc_pkg::CODE_W-1:0]     rsp_code_ch0,
   input logic [sptc_pkg::CODE_W-1:0]     rsp_code_ch1,
   input logic [sptc_pkg::CODE_W-1:0]     rsp_code_ch2
);

   // After reset no result is pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // After reset the input is open.
   a_reset_open: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   // A result without a valid centre carries all-zero fields.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_code_valid) |->
         (rsp_centre_column == '0) && (rsp_centre_row == '0) &&
         (rsp_code_ch0 == '0) && (rsp_code_ch1 == '0) && (rsp_code_ch2 == '0))
      else $error("invalid centre with nonzero fields");

   // A valid centre lies at least two rows into the frame.
   a_centre_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_code_valid) |->
         (rsp_centre_row >= sptc_pkg::POS_W'(sptc_pkg::WINDOW_RADIUS)))
      else $error("valid centre too close to top border");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         rsp_valid && $stable(rsp_code_valid) && $stable(rsp_centre_column) &&
         $stable(rsp_centre_row) && $stable(rsp_code_ch0) &&
         $stable(rsp_code_ch1) && $stable(rsp_code_ch2))
      else $error("stalled result changed");

endmodule

bind six_point_texture_code_core sptc_checker u_sptc_checker (.*);

[verif/tb_six_point_texture_code_core.sv]
// Self-checking testbench for the six-point texture code block.
module tb_six_point_texture_code_core;
   import sptc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int ROW_CAP      = 2048;
   localparam int STORE_WIDTH  = MAX_WIDTH_DEF;

   // An address past the last register; writes there must change nothing.
   localparam reg_index_type REG_SPARE = 2'd3;

   // Neighbor taps in the 5x5 window (row 0 oldest, column 4 newest), in code bit order.
   localparam int TAP_ROW [CODE_W] = '{0, 1, 1, 3, 3, 4};
   localparam int TAP_COL [CODE_W] = '{2, 0, 4, 0, 4, 2};

   typedef enum {FILL_RANDOM, FILL_NEAR, FILL_EXTREME} fill_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_frame_start;
   logic [CH_W-1:0]       req_pixel_ch0;
   logic [CH_W-1:0]       req_pixel_ch1;
   logic [CH_W-1:0]       req_pixel_ch2;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_code_valid;
   logic [POS_W-1:0]      rsp_centre_column;
   logic [POS_W-1:0]      rsp_centre_row;
   logic [CODE_W-1:0]     rsp_code_ch0;
   logic [CODE_W-1:0]     rsp_code_ch1;
   logic [CODE_W-1:0]     rsp_code_ch2;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: its own copy of registers, counters, line stores and window.
   logic [CFG_W-1:0]  cfg_width;
   logic [CFG_W-1:0]  cfg_height;
   logic [HYST_W-1:0] cfg_hyst;
   int unsigned       col_pos;
   int unsigned       row_pos;
   pixel_type         line_store [LINES][STORE_WIDTH];
   pixel_type         win_px [WIN][WIN];

   result_type expected_codes [$];

   int        error_count = 0;
   int        result_count = 0;
   int        cycle_count = 0;
   int        sender_idle_pct = 19;
   int        receiver_idle_pct = 87;
   int        stall_hold_cycles = 0;
   bit        stray_starts = 0;
   pixel_type near_base;

   six_point_texture_code_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_start   (req_frame_start),
      .req_pixel_ch0     (req_pixel_ch0),
      .req_pixel_ch1     (req_pixel_ch1),
      .req_pixel_ch2     (req_pixel_ch2),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_valid    (rsp_code_valid),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_code_ch0      (rsp_code_ch0),
      .rsp_code_ch1      (rsp_code_ch1),
      .rsp_code_ch2      (rsp_code_ch2),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Free-running cycle count with a hard stop for a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   // Texture code of one channel from the current window.
   function automatic logic [CODE_W-1:0] channel_code(int k);
      int center_val;
      int tap_val;
      logic [CODE_W-1:0] code;
      center_val = win_px[2][2][CH_W*k +: CH_W];
      code = '0;
      for (int b = 0; b < CODE_W; b++) begin
         tap_val = win_px[TAP_ROW[b]][TAP_COL[b]][CH_W*k +: CH_W];
         code[b] = (center_val - tap_val + int'(cfg_hyst) >= 0);
      end
      return code;
   endfunction

   // Takes one pixel into the predictor and returns the result it causes.
   function automatic result_type step_texture_codes(logic start, pixel_type px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      pixel_type fresh [WIN];
      result_type res;
      w = (cfg_width == 0) ? 1 : ((cfg_width > STORE_WIDTH) ? STORE_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : ((cfg_height > ROW_CAP) ? ROW_CAP : cfg_height);
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = (col_pos >= STORE_WIDTH) ? STORE_WIDTH - 1 : col_pos;

      // New window column: oldest line first, incoming pixel last.
      for (int i = 0; i < LINES; i++) fresh[i] = line_store[LINES - 1 - i][c];
      fresh[WIN - 1] = px;
      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN - 1; j++) win_px[i][j] = win_px[i][j + 1];
         win_px[i][WIN - 1] = fresh[i];
      end
      for (int i = LINES - 1; i > 0; i--) line_store[i][c] = line_store[i - 1][c];
      line_store[0][c] = px;

      res = '0;
      if (col_pos >= EDGE_MIN && row_pos >= EDGE_MIN && col_pos < w && row_pos < h) begin
         res.pos.code_valid = 1'b1;
         res.pos.col = POS_W'(col_pos - 2);
         res.pos.row = POS_W'(row_pos - 2);
         for (int k = 0; k < NUM_CH; k++) res.codes[k] = channel_code(k);
      end

      // Raster advance; a counter past a lowered limit wraps here.
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) row_pos = 0;
         else row_pos++;
      end else begin
         col_pos++;
      end
      return res;
   endfunction

   function automatic pixel_type make_pixel(fill_style_type fill);
      pixel_type px;
      int v;
      for (int k = 0; k < NUM_CH; k++) begin
         case (fill)
            FILL_NEAR: begin
               v = near_base[CH_W*k +: CH_W];
               v = v + int'($urandom_range(8)) - 4;
               if (v < 0) v = 0;
               else if (v > 255) v = 255;
            end
            FILL_EXTREME: v = ($urandom_range(1) != 0) ? 255 : 0;
            default: v = $urandom_range(255);
         endcase
         px[CH_W*k +: CH_W] = v[CH_W-1:0];
      end
      return px;
   endfunction

   // Offers one item, with random idle cycles ahead of it, and records its result.
   task automatic send_pixel(input logic start, input pixel_type px);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid       <= 1'b1;
      req_frame_start <= start;
      req_pixel_ch0   <= px[7:0];
      req_pixel_ch1   <= px[15:8];
      req_pixel_ch2   <= px[23:16];
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_codes.push_back(step_texture_codes(start, px));
   endtask

   // Sends a run of pixels; the first one may open a frame.
   task automatic send_run(input logic open_frame, input int count, input fill_style_type fill);
      logic start;
      near_base = make_pixel(FILL_RANDOM);
      for (int p = 0; p < count; p++) begin
         start = (p == 0) ? open_frame : (stray_starts && $urandom_range(255) == 0);
         send_pixel(start, make_pixel(fill));
      end
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_codes.size() != 0);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = data[CFG_W-1:0];
         REG_IMAGE_HEIGHT: cfg_height = data[CFG_W-1:0];
         REG_HYSTERESIS:   cfg_hyst   = data[HYST_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] got;
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  want = CSR_DATA_W'(cfg_width);
         REG_IMAGE_HEIGHT: want = CSR_DATA_W'(cfg_height);
         default:          want = CSR_DATA_W'(cfg_hyst);
      endcase
      if (got !== want)
         flag_error($sformatf("register %0d read: expected %0d, actual %0d", idx, want, got));
      @(posedge clock);
   endtask

   task automatic check_all_registers();
      check_register(REG_IMAGE_WIDTH);
      check_register(REG_IMAGE_HEIGHT);
      check_register(REG_HYSTERESIS);
   endtask

   task automatic set_geometry(input int w, input int h, input int hy);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_HYSTERESIS, hy);
   endtask

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
         flag_error($sformatf("result %0d %s: expected %0d, actual %0d",
                              result_count, name, want, got));
   endfunction

   // Compares one accepted result with the oldest expected one.
   function automatic void check_result();
      result_type want;
      if (expected_codes.size() == 0) begin
         flag_error($sformatf("result with nothing expected at row %0d column %0d",
                              rsp_centre_row, rsp_centre_column));
         return;
      end
      want = expected_codes.pop_front();
      compare_field("code_valid", want.pos.code_valid, rsp_code_valid);
      compare_field("centre_column", want.pos.col, rsp_centre_column);
      compare_field("centre_row", want.pos.row, rsp_centre_row);
      compare_field("code_ch0", want.codes[0], rsp_code_ch0);
      compare_field("code_ch1", want.codes[1], rsp_code_ch1);
      compare_field("code_ch2", want.codes[2], rsp_code_ch2);
      result_count++;
   endfunction

   // Result side: checks each accepted item, then picks the stall for the next cycle.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result();
         if (stall_hold_cycles > 0) begin
            stall_hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // Reset values, writes of every register, and a write past the last one.
   task automatic test_register_access();
      check_all_registers();
      set_geometry(2048, 5, 255);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      check_all_registers();
   endtask

   // One 5x5 frame whose single valid center sits on the hysteresis boundary.
   task automatic test_directed_window();
      int unsigned spot_r [7] = '{2, 0, 1, 1, 3, 3, 4};
      int unsigned spot_c [7] = '{2, 2, 0, 4, 0, 4, 2};
      pixel_type spot_px [7] = '{24'hFF_00_64, 24'hFF_03_67, 24'h00_04_68, 24'hFF_00_00,
                                 24'h00_FF_FF, 24'hFE_02_61, 24'hFF_FF_64};
      pixel_type px;
      set_geometry(5, 5, 3);
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            px = make_pixel(FILL_RANDOM);
            for (int s = 0; s < 7; s++)
               if (spot_r[s] == r && spot_c[s] == c) px = spot_px[s];
            send_pixel(r == 0 && c == 0, px);
         end
      end
      wait_drained();
   endtask

   // Width and height of zero, then far above the limit, then width five.
   task automatic test_size_extremes();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_geometry(0, 0, 0);
      check_all_registers();
      send_run(1'b1, 12, FILL_RANDOM);
      wait_drained();
      set_geometry(4095, 4095, 255);
      check_all_registers();
      send_run(1'b1, 40, FILL_EXTREME);
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, 5);
      send_run(1'b1, 45, FILL_RANDOM);
      wait_drained();
   endtask

   // Height, width and hysteresis lowered while counters sit past the new limits.
   task automatic test_midframe_registers();
      sender_idle_pct = 19;
      receiver_idle_pct = 87;
      set_geometry(10, 8, 2);
      send_run(1'b1, 65, FILL_NEAR);
      wait_drained();
      csr_write(REG_IMAGE_HEIGHT, 5);
      send_run(1'b0, 10, FILL_NEAR);
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, 5);
      send_run(1'b0, 15, FILL_NEAR);
      wait_drained();
      csr_write(REG_HYSTERESIS, 0);
      send_run(1'b0, 15, FILL_NEAR);
      wait_drained();
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_receiver_hold();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_geometry(8, 8, 4);
      stall_hold_cycles = 300;
      send_run(1'b1, 64, FILL_NEAR);
      wait_drained();
   endtask

   // Random small frames: mostly whole frames, some cut short or run past the end.
   task automatic test_random_frames(input int send_pct, input int recv_pct, input int budget);
      int sent;
      int w;
      int h;
      int hy;
      int total;
      fill_style_type fill;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      stray_starts = 1'b1;
      sent = 0;
      while (sent < budget) begin
         w = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(5, 12);
         h = $urandom_range(5, 9);
         case ($urandom_range(5))
            0: hy = 0;
            1: hy = 255;
            default: hy = $urandom_range(8);
         endcase
         wait_drained();
         set_geometry(w, h, hy);
         repeat ($urandom_range(1, 3)) begin
            total = w * h;
            case ($urandom_range(9))
               0: total = $urandom_range(1, total - 1);
               1: total = total + $urandom_range(1, 2 * w);
               default: ;
            endcase
            case ($urandom_range(4))
               0, 1: fill = FILL_RANDOM;
               2, 3: fill = FILL_NEAR;
               default: fill = FILL_EXTREME;
            endcase
            send_run(1'b1, total, fill);
            sent += total;
         end
      end
      stray_starts = 1'b0;
      wait_drained();
   endtask

   initial begin
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_hyst   = HYST_RESET;
      col_pos    = 0;
      row_pos    = 0;
      for (int i = 0; i < WIN; i++)
         for (int j = 0; j < WIN; j++) win_px[i][j] = '0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_frame_start <= 1'b0;
      req_pixel_ch0   <= '0;
      req_pixel_ch1   <= '0;
      req_pixel_ch2   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_window();
      test_size_extremes();
      test_midframe_registers();
      test_receiver_hold();
      test_random_frames(19, 87, 420);
      test_random_frames(87, 19, 420);
      test_random_frames(0, 0, 420);

      // Leave time for any stray result to show up.
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/sptc_pkg.sv
sv/sptc_ram.sv
sv/sptc_cell.sv
sv/sptc_code.sv
sv/six_point_texture_code_core.sv
sv/sptc_checker.sv
verif/tb_six_point_texture_code_core.sv
